// ----- sv/sv39ptw_pkg.sv -----
// Shared types and constants for the SV39 page table walker.
// Used by sv39ptw_out_fifo and sv39_page_table_walker_core; no dependencies.
package sv39ptw_pkg;

  // PTE and address layout
  localparam int PAGE_BITS   = 12;
  localparam int INDEX_BITS  = 9;
  localparam int PPN_BITS    = 44;
  localparam int PPN_POS     = 10;
  localparam int MADDR_BITS  = 56;

  localparam logic [3:0] MODE_SV39 = 4'd8;

  // PTE flag bit positions
  localparam int F_V = 0;
  localparam int F_R = 1;
  localparam int F_W = 2;
  localparam int F_X = 3;
  localparam int F_U = 4;
  localparam int F_A = 6;
  localparam int F_D = 7;

  // input item selector
  localparam logic OP_REQ  = 1'b0;
  localparam logic OP_RESP = 1'b1;

  // access kinds
  localparam logic [1:0] ACC_FETCH = 2'd0;
  localparam logic [1:0] ACC_LOAD  = 2'd1;
  localparam logic [1:0] ACC_STORE = 2'd2;

  // privilege levels
  localparam logic [1:0] PRIV_USER  = 2'd0;
  localparam logic [1:0] PRIV_SUPER = 2'd1;
  localparam logic [1:0] PRIV_MACH  = 2'd3;

  // output queue sizing
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = OUTQ_PTR_W + 1;

  typedef enum logic [1:0] {
    KIND_RD_REQ = 2'd0,
    KIND_WR_REQ = 2'd1,
    KIND_DONE   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t           kind;
    logic [55:0]     mem_addr;
    logic [63:0]     mem_wdata;
    logic [63:0]     phys_addr;
    logic            fault;
    logic [1:0]      fault_code;
    logic            last;
  } result_t;

  // push request from the walker into the output queue
  typedef struct packed {
    logic [1:0] count;   // 0, 1 or 2 items
    result_t    first;
    result_t    second;
  } push_t;

endpackage

// ----- sv/sv39ptw_out_fifo.sv -----
// Output result queue: takes up to two result items per cycle, hands out one.
// Depends on sv39ptw_pkg (result_t, push_t, queue sizing).
module sv39ptw_out_fifo import sv39ptw_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    room,      // space for two more items
  input  logic    pop,
  output logic    head_valid,
  output result_t head
);

  result_t                 entries [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0]   wr_ptr;
  logic [OUTQ_PTR_W-1:0]   rd_ptr;
  logic [OUTQ_CNT_W-1:0]   count;
  logic                    do_pop;
  logic [OUTQ_PTR_W-1:0]   wr_ptr_plus1;

  assign head_valid   = (count != '0);
  assign head         = entries[rd_ptr];
  assign room         = (count <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));
  assign do_pop       = pop && head_valid;
  assign wr_ptr_plus1 = wr_ptr + OUTQ_PTR_W'(1);

  // payload storage, no reset
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr_plus1] <= push.second;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OUTQ_PTR_W'(push.count);
      if (do_pop) begin
        rd_ptr <= rd_ptr + OUTQ_PTR_W'(1);
      end
      count <= count + OUTQ_CNT_W'(push.count) - OUTQ_CNT_W'(do_pop);
    end
  end

endmodule

// ----- sv/sv39_page_table_walker_core.sv -----
// SV39 page table walker core: input register, one-pass walk step, output queue.
// An accepted input item passes the input register and then the output queue
// before its first result item appears. Input takes one item per cycle while the
// queue has room; a successful leaf yields two result items, handed out one at a time.
// Reset (synchronous, rst high): walker idle, satp cleared, queue empty.
// Depends on sv39ptw_pkg and sv39ptw_out_fifo.
module sv39_page_table_walker_core import sv39ptw_pkg::*; #(
  parameter int LEVELS = 3
) (
  input  logic         clk,
  input  logic         rst,
  // configuration: satp
  input  logic         cfg_wen,
  input  logic [63:0]  cfg_wdata,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // [63:0] virt_addr, [65:64] access_kind, [67:66] priv_level,
  // [68] sum_bit, [132:69] pte_data, [135:133] zero
  input  logic [135:0] s_tdata,
  input  logic         s_tuser,   // [0] opcode
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // [55:0] mem_addr, [119:56] mem_wdata, [183:120] phys_addr,
  // [184] fault, [186:185] fault_code, [191:187] zero
  output logic [191:0] m_tdata,
  output logic [1:0]   m_tuser,   // [1:0] result_kind
  output logic         m_tlast
);

  localparam int LVL_W = $clog2(LEVELS);

  // entry address for one level: table base plus 8 * index
  function automatic logic [55:0] entry_addr(logic [43:0] ppn, logic [63:0] va,
                                             logic [LVL_W-1:0] lvl);
    logic [INDEX_BITS-1:0] idx;
    idx = va[PAGE_BITS + int'(lvl) * INDEX_BITS +: INDEX_BITS];
    return {ppn, idx, 3'b000};
  endfunction

  // configuration register
  logic [63:0] satp;

  always_ff @(posedge clk) begin
    if (rst) begin
      satp <= '0;
    end else if (cfg_wen) begin
      satp <= cfg_wdata;
    end
  end

  // input register
  logic        stg_valid;
  logic        stg_opcode;
  logic [63:0] stg_vaddr;
  logic [1:0]  stg_access;
  logic [1:0]  stg_priv;
  logic        stg_sum;
  logic [63:0] stg_pte;
  logic        q_room;
  logic        stg_fire;

  assign stg_fire = stg_valid && q_room;
  assign s_tready = !stg_valid || q_room;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (s_tready) begin
      stg_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      stg_opcode <= s_tuser;
      stg_vaddr  <= s_tdata[63:0];
      stg_access <= s_tdata[65:64];
      stg_priv   <= s_tdata[67:66];
      stg_sum    <= s_tdata[68];
      stg_pte    <= s_tdata[132:69];
    end
  end

  // walk state
  logic             walk_busy,     walk_busy_next;
  logic [LVL_W-1:0] walk_level,    walk_level_next;
  logic [63:0]      saved_vaddr,   saved_vaddr_next;
  logic [1:0]       saved_access,  saved_access_next;
  logic [1:0]       saved_priv,    saved_priv_next;
  logic             saved_sum,     saved_sum_next;
  logic [55:0]      pte_address,   pte_address_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_busy    <= 1'b0;
      walk_level   <= '0;
      saved_vaddr  <= '0;
      saved_access <= '0;
      saved_priv   <= '0;
      saved_sum    <= 1'b0;
      pte_address  <= '0;
    end else begin
      walk_busy    <= walk_busy_next;
      walk_level   <= walk_level_next;
      saved_vaddr  <= saved_vaddr_next;
      saved_access <= saved_access_next;
      saved_priv   <= saved_priv_next;
      saved_sum    <= saved_sum_next;
      pte_address  <= pte_address_next;
    end
  end

  // one walk step
  push_t            push;
  logic [63:0]      pte;
  logic [63:0]      pte_upd;
  logic             pte_bad;
  logic             is_leaf;
  logic             perm_ok;
  logic [6:0]       obits;
  logic [63:0]      pa;
  logic [43:0]      next_ppn;

  always_comb begin
    pte      = stg_pte;
    next_ppn = pte[PPN_POS +: PPN_BITS];
    pte_bad  = !pte[F_V] || (!pte[F_R] && pte[F_W]);
    is_leaf  = pte[F_R] || pte[F_X];

    // permission check against the saved request
    perm_ok = 1'b1;
    case (saved_access)
      ACC_FETCH: if (!pte[F_X]) perm_ok = 1'b0;
      ACC_STORE: if (!pte[F_W]) perm_ok = 1'b0;
      default:   if (!pte[F_R]) perm_ok = 1'b0;
    endcase
    if (saved_priv == PRIV_USER && !pte[F_U]) perm_ok = 1'b0;
    if (saved_priv == PRIV_SUPER && pte[F_U] && !saved_sum) perm_ok = 1'b0;

    // accessed / dirty update and physical address
    pte_upd        = pte;
    pte_upd[F_A]   = 1'b1;
    if (saved_access == ACC_STORE) pte_upd[F_D] = 1'b1;
    obits = 7'(PAGE_BITS + int'(walk_level) * INDEX_BITS);
    pa    = {8'b0, next_ppn, 12'b0} | (saved_vaddr & ~(~64'd0 << obits));

    walk_busy_next    = walk_busy;
    walk_level_next   = walk_level;
    saved_vaddr_next  = saved_vaddr;
    saved_access_next = saved_access;
    saved_priv_next   = saved_priv;
    saved_sum_next    = saved_sum;
    pte_address_next  = pte_address;
    push              = '0;

    if (stg_fire) begin
      if (stg_opcode == OP_REQ) begin
        walk_busy_next = 1'b0;
        push.count     = 2'd1;
        push.first.last = 1'b1;
        if (stg_priv == PRIV_MACH || satp[63:60] != MODE_SV39) begin
          // translation off: address passes through
          push.first.kind      = KIND_DONE;
          push.first.phys_addr = stg_vaddr;
        end else begin
          saved_vaddr_next  = stg_vaddr;
          saved_access_next = (stg_access == ACC_FETCH || stg_access == ACC_STORE) ?
                              stg_access : ACC_LOAD;
          saved_priv_next   = stg_priv;
          saved_sum_next    = stg_sum;
          walk_level_next   = LVL_W'(LEVELS - 1);
          pte_address_next  = entry_addr(satp[43:0], stg_vaddr, LVL_W'(LEVELS - 1));
          walk_busy_next    = 1'b1;
          push.first.kind     = KIND_RD_REQ;
          push.first.mem_addr = pte_address_next;
        end
      end else if (walk_busy) begin
        push.count      = 2'd1;
        push.first.last = 1'b1;
        if (pte_bad || (is_leaf && !perm_ok) || (!is_leaf && walk_level == '0)) begin
          // page fault
          walk_busy_next        = 1'b0;
          push.first.kind       = KIND_DONE;
          push.first.fault      = 1'b1;
          push.first.fault_code = saved_access;
        end else if (is_leaf) begin
          // leaf: write back the PTE, then report the address
          walk_busy_next        = 1'b0;
          push.count            = 2'd2;
          push.first.kind       = KIND_WR_REQ;
          push.first.mem_addr   = pte_address;
          push.first.mem_wdata  = pte_upd;
          push.first.last       = 1'b0;
          push.second.kind      = KIND_DONE;
          push.second.phys_addr = pa;
          push.second.last      = 1'b1;
        end else begin
          // pointer: descend one level
          walk_level_next     = walk_level - LVL_W'(1);
          pte_address_next    = entry_addr(next_ppn, saved_vaddr, walk_level_next);
          push.first.kind     = KIND_RD_REQ;
          push.first.mem_addr = pte_address_next;
        end
      end
    end
  end

  // output queue
  result_t head;

  sv39ptw_out_fifo u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (q_room),
    .pop        (m_tready),
    .head_valid (m_tvalid),
    .head       (head)
  );

  assign m_tdata = {5'b0, head.fault_code, head.fault, head.phys_addr,
                    head.mem_wdata, head.mem_addr};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

endmodule
